// ===== rtl/ptt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the point-in-trapezoid test: word types, edge setup types and the
// divider stage word. No dependencies.
package ptt_pkg;

  localparam int COORD_W   = 16;
  localparam int DIV_STEPS = COORD_W;
  // edge pipe: setup, multiply, one stage per quotient bit, final add
  localparam int EDGE_LAT  = DIV_STEPS + 3;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TOP_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_TOP_Z     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOTTOM_X  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BOTTOM_Z  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TOP_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_TOP_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOTTOM_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BOTTOM_Z = 3'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic                      inside_res;
    logic signed [COORD_W-1:0] left_edge_x;
    logic signed [COORD_W-1:0] right_edge_x;
  } out_word_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] top_z;
    logic signed [COORD_W-1:0] bot_x;
    logic signed [COORD_W-1:0] bot_z;
  } edge_cfg_t;

  typedef enum logic [1:0] {
    SEL_TOP,
    SEL_BOTTOM,
    SEL_INTERP
  } edge_sel_t;

  typedef struct packed {
    edge_sel_t                 sel;
    logic                      neg;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] bot_x;
    logic        [COORD_W-1:0] den;
    logic        [COORD_W-1:0] mag;
    logic        [COORD_W-1:0] dzp;
  } edge_prep_t;

  typedef struct packed {
    edge_sel_t                 sel;
    logic                      neg;
    logic signed [COORD_W-1:0] top_x;
    logic signed [COORD_W-1:0] bot_x;
    logic        [COORD_W-1:0] den;
    logic        [COORD_W-1:0] rem;
    logic        [COORD_W-1:0] num_lo;
    logic        [COORD_W-1:0] quo;
  } div_word_t;

endpackage

// ===== rtl/ptt_div_step.sv =====
`timescale 1ns / 1ps
// One registered restoring-division step: one quotient bit per stage.
// Depends on ptt_pkg.
module ptt_div_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  ptt_pkg::div_word_t in_stage,
  output logic               out_vld,
  output ptt_pkg::div_word_t out_stage
);

  logic               vld_r;
  ptt_pkg::div_word_t stage_r;
  ptt_pkg::div_word_t stage_nxt;
  logic [ptt_pkg::COORD_W:0] trial;
  logic [ptt_pkg::COORD_W:0] diff;
  logic                      ge;

  always_comb begin
    trial     = {in_stage.rem, in_stage.num_lo[ptt_pkg::COORD_W-1]};
    diff      = trial - {1'b0, in_stage.den};
    ge        = (trial >= {1'b0, in_stage.den});
    stage_nxt = in_stage;
    stage_nxt.rem    = ge ? diff[ptt_pkg::COORD_W-1:0] : trial[ptt_pkg::COORD_W-1:0];
    stage_nxt.num_lo = {in_stage.num_lo[ptt_pkg::COORD_W-2:0], 1'b0};
    stage_nxt.quo    = {in_stage.quo[ptt_pkg::COORD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= in_vld;
    end
    stage_r <= stage_nxt;
  end

  assign out_vld   = vld_r;
  assign out_stage = stage_r;

endmodule

// ===== rtl/ptt_edge.sv =====
`timescale 1ns / 1ps
// Edge x interpolation pipe: setup, 16x16 multiply, pipelined divider stages
// and clamp/add. Depends on ptt_pkg and ptt_div_step.
module ptt_edge (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ptt_pkg::edge_cfg_t                  cfg,
  input  logic                                in_vld,
  input  logic signed [ptt_pkg::COORD_W-1:0]  in_z,
  output logic                                out_vld,
  output logic signed [ptt_pkg::COORD_W-1:0]  out_x
);

  localparam int W = ptt_pkg::COORD_W;
  localparam int N = ptt_pkg::DIV_STEPS;

  ptt_pkg::edge_prep_t prep_r, prep_nxt;
  logic                prep_vld_r;
  ptt_pkg::div_word_t  mul_nxt;
  ptt_pkg::div_word_t  mul_r;
  logic                mul_vld_r;
  logic [2*W-1:0]      prod;

  ptt_pkg::div_word_t  div_d [N+1];
  logic                div_v [N+1];

  logic signed [W:0]   dx, dzp, den;
  logic signed [W:0]   sq, sum;
  logic signed [W-1:0] x_r, x_nxt;
  logic                x_vld_r;

  always_comb begin
    dx  = {cfg.bot_x[W-1], cfg.bot_x} - {cfg.top_x[W-1], cfg.top_x};
    dzp = {in_z[W-1], in_z} - {cfg.top_z[W-1], cfg.top_z};
    den = {cfg.bot_z[W-1], cfg.bot_z} - {cfg.top_z[W-1], cfg.top_z};
    if ($signed(in_z) <= $signed(cfg.top_z)) begin
      prep_nxt.sel = ptt_pkg::SEL_TOP;
    end else if ($signed(in_z) >= $signed(cfg.bot_z)) begin
      prep_nxt.sel = ptt_pkg::SEL_BOTTOM;
    end else begin
      prep_nxt.sel = ptt_pkg::SEL_INTERP;
    end
    prep_nxt.neg   = dx[W];
    prep_nxt.mag   = dx[W] ? W'(-dx) : dx[W-1:0];
    prep_nxt.dzp   = dzp[W-1:0];
    prep_nxt.den   = den[W-1:0];
    prep_nxt.top_x = cfg.top_x;
    prep_nxt.bot_x = cfg.bot_x;
  end

  // quotient fits W bits, so the upper half of the product is already below den
  always_comb begin
    prod           = prep_r.mag * prep_r.dzp;
    mul_nxt.sel    = prep_r.sel;
    mul_nxt.neg    = prep_r.neg;
    mul_nxt.top_x  = prep_r.top_x;
    mul_nxt.bot_x  = prep_r.bot_x;
    mul_nxt.den    = prep_r.den;
    mul_nxt.rem    = prod[2*W-1:W];
    mul_nxt.num_lo = prod[W-1:0];
    mul_nxt.quo    = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_vld_r <= 1'b0;
      mul_vld_r  <= 1'b0;
    end else begin
      prep_vld_r <= in_vld;
      mul_vld_r  <= prep_vld_r;
    end
    prep_r <= prep_nxt;
    mul_r  <= mul_nxt;
  end

  assign div_d[0] = mul_r;
  assign div_v[0] = mul_vld_r;

  for (genvar g = 0; g < N; g++) begin : g_div
    ptt_div_step u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_vld    (div_v[g]),
      .in_stage  (div_d[g]),
      .out_vld   (div_v[g+1]),
      .out_stage (div_d[g+1])
    );
  end

  always_comb begin
    sq  = div_d[N].neg ? -$signed({1'b0, div_d[N].quo}) : $signed({1'b0, div_d[N].quo});
    sum = $signed({div_d[N].top_x[W-1], div_d[N].top_x}) + sq;
    case (div_d[N].sel)
      ptt_pkg::SEL_TOP:    x_nxt = div_d[N].top_x;
      ptt_pkg::SEL_BOTTOM: x_nxt = div_d[N].bot_x;
      ptt_pkg::SEL_INTERP: x_nxt = sum[W-1:0];
      default:             x_nxt = div_d[N].top_x;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= 1'b0;
    end else begin
      x_vld_r <= div_v[N];
    end
    x_r <= x_nxt;
  end

  assign out_vld = x_vld_r;
  assign out_x   = x_r;

endmodule

// ===== rtl/point_in_trapezoid_test.sv =====
`timescale 1ns / 1ps
// Top level of the point-in-trapezoid test: config registers, left/right edge pipes,
// span/point delay line and result register. Depends on ptt_pkg and ptt_edge.
//
// Usage:
//   Input: drive in_data (point_x, point_z) and pulse start; a word is taken at
//   every edge where start is high and busy is low. busy is always low, so a
//   new point may enter every cycle.
//   Output: out_strobe is high for exactly one cycle with out_data (inside_res,
//   left_edge_x, right_edge_x). Results leave in input order.
//   Pipeline: from the accepting edge to the strobe cycle lie edge setup,
//   one multiply stage, 16 divider stages (one quotient bit each), the edge
//   add/clamp stage and the result register. Throughput: one word per cycle.
//   Config: cfg_we with cfg_idx/cfg_data writes one 16-bit register at the edge;
//   write only while no point is in flight.
//   Reset (rst_n low, synchronous): the config registers read 0 and the pipe empties.
//   The receiver cannot stall; a result must be taken in its strobe cycle.
module point_in_trapezoid_test (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  ptt_pkg::in_word_t                     in_data,
  output logic                                  out_strobe,
  output ptt_pkg::out_word_t                    out_data,
  input  logic                                  cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [ptt_pkg::COORD_W-1:0]           cfg_data
);

  localparam int W   = ptt_pkg::COORD_W;
  localparam int LAT = ptt_pkg::EDGE_LAT;

  ptt_pkg::edge_cfg_t left_r, right_r;
  logic               accept;
  logic               span;
  logic               l_vld, r_vld;
  logic signed [W-1:0] l_x, r_x;

  logic signed [W-1:0] px_r   [LAT];
  logic                span_r [LAT];

  logic               strobe_r;
  ptt_pkg::out_word_t out_r, out_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign span   = ($signed(in_data.point_z) >= $signed(left_r.top_z)) &&
                  ($signed(in_data.point_z) <= $signed(left_r.bot_z));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        ptt_pkg::REG_LEFT_TOP_X:     left_r.top_x  <= cfg_data;
        ptt_pkg::REG_LEFT_TOP_Z:     left_r.top_z  <= cfg_data;
        ptt_pkg::REG_LEFT_BOTTOM_X:  left_r.bot_x  <= cfg_data;
        ptt_pkg::REG_LEFT_BOTTOM_Z:  left_r.bot_z  <= cfg_data;
        ptt_pkg::REG_RIGHT_TOP_X:    right_r.top_x <= cfg_data;
        ptt_pkg::REG_RIGHT_TOP_Z:    right_r.top_z <= cfg_data;
        ptt_pkg::REG_RIGHT_BOTTOM_X: right_r.bot_x <= cfg_data;
        ptt_pkg::REG_RIGHT_BOTTOM_Z: right_r.bot_z <= cfg_data;
        default: ;
      endcase
    end
  end

  ptt_edge u_left (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (left_r),
    .in_vld  (accept),
    .in_z    (in_data.point_z),
    .out_vld (l_vld),
    .out_x   (l_x)
  );

  ptt_edge u_right (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (right_r),
    .in_vld  (accept),
    .in_z    (in_data.point_z),
    .out_vld (r_vld),
    .out_x   (r_x)
  );

  // point x and span flag ride alongside the edge pipes
  always_ff @(posedge clk) begin
    px_r[0]   <= in_data.point_x;
    span_r[0] <= span;
    for (int i = 1; i < LAT; i++) begin
      px_r[i]   <= px_r[i-1];
      span_r[i] <= span_r[i-1];
    end
  end

  always_comb begin
    out_nxt.inside_res   = span_r[LAT-1] && ($signed(px_r[LAT-1]) >= $signed(l_x)) &&
                           ($signed(px_r[LAT-1]) <= $signed(r_x));
    out_nxt.left_edge_x  = l_x;
    out_nxt.right_edge_x = r_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= l_vld;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  a_edges_aligned : assert property (@(posedge clk) disable iff (!rst_n)
    l_vld == r_vld)
    else $error("left and right edge pipes out of step");

  a_strobe_from_accept : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LAT + 1))
    else $error("result strobe without a matching accepted word");

  a_inside_ordered : assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.inside_res) |->
      ($signed(out_data.left_edge_x) <= $signed(out_data.right_edge_x)))
    else $error("inside reported with crossed edges");
`endif

endmodule

// ===== verif/point_in_trapezoid_checker.sv =====
`timescale 1ns / 1ps
// Checker for point_in_trapezoid_test: tracks the edge registers, predicts each point word's
// result and compares every strobed result with the oldest prediction. Depends on ptt_pkg.
module point_in_trapezoid_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  ptt_pkg::in_word_t  in_data,
  input  logic               out_strobe,
  input  ptt_pkg::out_word_t out_data,
  input  logic               cfg_we,
  input  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [ptt_pkg::COORD_W-1:0]   cfg_data,
  output int                 fail_count,
  output int                 pending
);

  ptt_pkg::edge_cfg_t left_edge;
  ptt_pkg::edge_cfg_t right_edge;
  ptt_pkg::out_word_t result_q[$];

  function automatic logic signed [ptt_pkg::COORD_W-1:0] interp_edge_x(
    ptt_pkg::edge_cfg_t e, logic signed [ptt_pkg::COORD_W-1:0] z);
    longint span;
    longint prod;
    if (z <= e.top_z) return e.top_x;
    if (z >= e.bot_z) return e.bot_x;
    span = longint'(e.bot_z) - longint'(e.top_z);
    prod = (longint'(e.bot_x) - longint'(e.top_x)) * (longint'(z) - longint'(e.top_z));
    return ptt_pkg::COORD_W'(longint'(e.top_x) + prod / span);
  endfunction

  function automatic ptt_pkg::out_word_t classify_point(ptt_pkg::in_word_t p);
    ptt_pkg::out_word_t r;
    r.left_edge_x  = interp_edge_x(left_edge, p.point_z);
    r.right_edge_x = interp_edge_x(right_edge, p.point_z);
    r.inside_res   = (p.point_z >= left_edge.top_z) && (p.point_z <= left_edge.bot_z) &&
                     (p.point_x >= r.left_edge_x) && (p.point_x <= r.right_edge_x);
    return r;
  endfunction

  always @(posedge clk) begin
    ptt_pkg::out_word_t exp_w;
    logic bad;
    if (!rst_n) begin
      left_edge  = '0;
      right_edge = '0;
      result_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          ptt_pkg::REG_LEFT_TOP_X:     left_edge.top_x  = cfg_data;
          ptt_pkg::REG_LEFT_TOP_Z:     left_edge.top_z  = cfg_data;
          ptt_pkg::REG_LEFT_BOTTOM_X:  left_edge.bot_x  = cfg_data;
          ptt_pkg::REG_LEFT_BOTTOM_Z:  left_edge.bot_z  = cfg_data;
          ptt_pkg::REG_RIGHT_TOP_X:    right_edge.top_x = cfg_data;
          ptt_pkg::REG_RIGHT_TOP_Z:    right_edge.top_z = cfg_data;
          ptt_pkg::REG_RIGHT_BOTTOM_X: right_edge.bot_x = cfg_data;
          ptt_pkg::REG_RIGHT_BOTTOM_Z: right_edge.bot_z = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) result_q.push_back(classify_point(in_data));
      if (out_strobe) begin
        bad = 1'b0;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, expected none got %0b %0d %0d", $time,
                   out_data.inside_res, out_data.left_edge_x, out_data.right_edge_x);
          bad = 1'b1;
        end else begin
          exp_w = result_q.pop_front();
          if (out_data.inside_res !== exp_w.inside_res) begin
            $display("%0t: inside_res mismatch, expected %0b got %0b", $time,
                     exp_w.inside_res, out_data.inside_res);
            bad = 1'b1;
          end
          if (out_data.left_edge_x !== exp_w.left_edge_x) begin
            $display("%0t: left_edge_x mismatch, expected %0d got %0d", $time,
                     exp_w.left_edge_x, out_data.left_edge_x);
            bad = 1'b1;
          end
          if (out_data.right_edge_x !== exp_w.right_edge_x) begin
            $display("%0t: right_edge_x mismatch, expected %0d got %0d", $time,
                     exp_w.right_edge_x, out_data.right_edge_x);
            bad = 1'b1;
          end
        end
        if (bad) fail_count <= fail_count + 1;
      end
    end
    pending <= result_q.size();
  end

endmodule

// ===== verif/tb_point_in_trapezoid_test.sv =====
`timescale 1ns / 1ps
// Testbench top for point_in_trapezoid_test: clock, reset, edge setups and point words.
// Depends on ptt_pkg, point_in_trapezoid_test and point_in_trapezoid_checker.
module tb_point_in_trapezoid_test;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  ptt_pkg::in_word_t  in_data;
  logic               out_strobe;
  ptt_pkg::out_word_t out_data;
  logic               cfg_we;
  logic [ptt_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [ptt_pkg::COORD_W-1:0]   cfg_data;
  int                 fail_count;
  int                 pending;
  logic               no_idle;

  point_in_trapezoid_test i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_idx, .cfg_data
  );

  point_in_trapezoid_checker i_checker (
    .clk, .rst_n, .start, .busy, .in_data, .out_strobe, .out_data,
    .cfg_we, .cfg_idx, .cfg_data, .fail_count, .pending
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic logic signed [ptt_pkg::COORD_W-1:0] rand_coord(int lo, int hi);
    return ptt_pkg::COORD_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  function automatic logic signed [ptt_pkg::COORD_W-1:0] pick_extreme();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd1;
      3: return 16'sd0;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic ptt_pkg::in_word_t mk_point(int x, int z);
    ptt_pkg::in_word_t p;
    p.point_x = ptt_pkg::COORD_W'(x);
    p.point_z = ptt_pkg::COORD_W'(z);
    return p;
  endfunction

  function automatic ptt_pkg::edge_cfg_t mk_edge(int tx, int tz, int bx, int bz);
    ptt_pkg::edge_cfg_t e;
    e.top_x = ptt_pkg::COORD_W'(tx);
    e.top_z = ptt_pkg::COORD_W'(tz);
    e.bot_x = ptt_pkg::COORD_W'(bx);
    e.bot_z = ptt_pkg::COORD_W'(bz);
    return e;
  endfunction

  task automatic apply_edges(ptt_pkg::edge_cfg_t l, ptt_pkg::edge_cfg_t r);
    logic [ptt_pkg::CFG_IDX_W-1:0] idx;
    idx = ptt_pkg::REG_LEFT_TOP_X;
    repeat (8) begin
      @(negedge clk);
      cfg_we  <= 1'b1;
      cfg_idx <= idx;
      case (idx)
        ptt_pkg::REG_LEFT_TOP_X:     cfg_data <= l.top_x;
        ptt_pkg::REG_LEFT_TOP_Z:     cfg_data <= l.top_z;
        ptt_pkg::REG_LEFT_BOTTOM_X:  cfg_data <= l.bot_x;
        ptt_pkg::REG_LEFT_BOTTOM_Z:  cfg_data <= l.bot_z;
        ptt_pkg::REG_RIGHT_TOP_X:    cfg_data <= r.top_x;
        ptt_pkg::REG_RIGHT_TOP_Z:    cfg_data <= r.top_z;
        ptt_pkg::REG_RIGHT_BOTTOM_X: cfg_data <= r.bot_x;
        default:                     cfg_data <= r.bot_z;
      endcase
      idx = idx + 1'b1;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send_point(ptt_pkg::in_word_t w);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic ptt_pkg::edge_cfg_t rand_edge(int kind, int w, logic left_side);
    ptt_pkg::edge_cfg_t e;
    if (kind == 3) begin
      e = {$urandom, $urandom};
    end else if (kind == 4) begin
      e.top_x = pick_extreme();
      e.top_z = pick_extreme();
      e.bot_x = pick_extreme();
      e.bot_z = pick_extreme();
    end else begin
      e.top_z = rand_coord(-w, w);
      e.bot_z = rand_coord(e.top_z, w);
      if (left_side) begin
        e.top_x = rand_coord(-w, w / 4);
        e.bot_x = rand_coord(-w, w / 4);
      end else begin
        e.top_x = rand_coord(-w / 4, w);
        e.bot_x = rand_coord(-w / 4, w);
      end
    end
    return e;
  endfunction

  initial begin
    ptt_pkg::edge_cfg_t l_cfg;
    ptt_pkg::edge_cfg_t r_cfg;
    ptt_pkg::in_word_t  p;
    int                 kind;
    int                 w;
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    cfg_we   = 1'b0;
    cfg_idx  = '0;
    cfg_data = '0;
    no_idle  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // all-zero edges straight out of reset
    send_point(mk_point(0, 0));
    send_point(mk_point(1, 0));
    send_point(mk_point(-1, 0));
    send_point(mk_point(0, 1));
    drain();

    // ordinary trapezoid, left edge exercises truncation toward zero
    apply_edges(mk_edge(-100, -50, -201, 50), mk_edge(100, -50, 300, 50));
    send_point(mk_point(0, -51));
    send_point(mk_point(-100, -50));
    send_point(mk_point(100, -50));
    send_point(mk_point(101, -50));
    send_point(mk_point(-101, -49));
    send_point(mk_point(-102, -49));
    send_point(mk_point(-150, 0));
    send_point(mk_point(-151, 0));
    send_point(mk_point(200, 0));
    send_point(mk_point(-201, 50));
    send_point(mk_point(300, 50));
    send_point(mk_point(0, 51));
    drain();

    // full-range crossed edges
    apply_edges(mk_edge(-32768, -32768, 32767, 32767), mk_edge(32767, -32768, -32768, 32767));
    send_point(mk_point(-32768, -32768));
    send_point(mk_point(32767, 32767));
    send_point(mk_point(0, 0));
    send_point(mk_point(-32768, 32767));
    send_point(mk_point(32767, -32768));
    drain();

    // inverted left span, zero right span
    apply_edges(mk_edge(-10, 100, -10, -100), mk_edge(10, 0, 20, 0));
    send_point(mk_point(0, 0));
    send_point(mk_point(0, 100));
    send_point(mk_point(0, -100));
    drain();

    for (int ph = 0; ph < 15; ph++) begin
      kind = ph % 5;
      case (kind)
        0: w = 20;
        1: w = 2000;
        default: w = 32767;
      endcase
      l_cfg = rand_edge(kind, w, 1'b1);
      r_cfg = rand_edge(kind, w, 1'b0);
      apply_edges(l_cfg, r_cfg);
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (120) begin
        if (kind <= 2 && $urandom_range(0, 3) != 0 && l_cfg.top_z <= l_cfg.bot_z) begin
          p.point_z = rand_coord(l_cfg.top_z, l_cfg.bot_z);
          p.point_x = (kind == 2) ? ptt_pkg::COORD_W'($urandom) : rand_coord(-w - 4, w + 4);
        end else begin
          p = $urandom;
        end
        send_point(p);
      end
      drain();
    end

    repeat (ptt_pkg::EDGE_LAT + 4) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
